>>> sv/bpbs_pkg.sv
// Shared types and constants for the bounded packet buffer simulator.
package bpbs_pkg;

	localparam int TIME_W = 32;
	localparam int PROC_W = 16;
	localparam int CFG_W  = 7;
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;

	localparam logic [CFG_W-1:0]  BUF_SIZE_RST     = 7'd64;
	localparam logic [APB_AW-1:0] ADDR_BUFFER_SIZE = 2'd0;

	localparam logic ALU_LE  = 1'b0;
	localparam logic ALU_ADD = 1'b1;

	typedef struct packed {
		logic              op;
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [TIME_W-1:0] sum;
		logic              le;
	} alu_rsp_t;

endpackage

>>> sv/bpbs_alu.sv
// Shared time unit: unsigned less-or-equal compare and modulo-2^32 add.
module bpbs_alu (
	input  bpbs_pkg::alu_req_t req,
	output bpbs_pkg::alu_rsp_t rsp
);
	import bpbs_pkg::*;

	always_comb begin
		rsp.le  = (req.a <= req.b);
		rsp.sum = '0;
		case (req.op)
			ALU_ADD: rsp.sum = req.a + req.b;
			default: rsp.sum = '0;
		endcase
	end

endmodule

>>> sv/bpbs_ring.sv
// Finish-time ring memory: one write port, one registered read port.
module bpbs_ring #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [bpbs_pkg::TIME_W-1:0] wr_data,
	input  logic [AW-1:0]               rd_addr,
	output logic [bpbs_pkg::TIME_W-1:0] rd_data
);
	import bpbs_pkg::*;

	logic [TIME_W-1:0] mem [DEPTH];
	logic [TIME_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/bounded_packet_buffer_sim_unit.sv
// Top level: tail-drop packet buffer simulator with sequencer, ring and shared time unit.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------
//   pkt      | pkt_valid/pkt_stall  | arrival_tick, service_ticks
//   res      | res_valid/res_stall  | dropped, start_tick
//   cfg      | APB psel/penable     | buffer_size at address 0
//
// A request pops expired entries, P being their number, one per cycle through the single
// compare unit, then takes a max step when queued (skipped when dropped) and an add step.
// pkt_stall is high from acceptance until the result is loaded into the output register.
// A stalled result holds the last step until the output register frees.
// Reset clears occupancy, head, last finish time and sets buffer_size to 64.
module bounded_packet_buffer_sim_unit #(
	parameter int DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpbs_pkg::APB_AW-1:0] paddr,
	input  logic [bpbs_pkg::APB_DW-1:0] pwdata,
	output logic [bpbs_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        pkt_valid,
	output logic                        pkt_stall,
	input  logic [bpbs_pkg::TIME_W-1:0] arrival_tick,
	input  logic [bpbs_pkg::PROC_W-1:0] service_ticks,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        dropped,
	output logic [bpbs_pkg::TIME_W-1:0] start_tick
);
	import bpbs_pkg::*;

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = AW + 1;
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int LIM_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_MAX  = 2'd2;
	localparam logic [1:0] ST_ADD  = 2'd3;

	logic [1:0]       state_q;
	logic [AW-1:0]    head_q;
	logic [OCC_W-1:0] occ_q;
	logic [TIME_W-1:0] last_q;
	logic [CFG_W-1:0] bsz_q;
	logic             res_valid_q;

	logic [TIME_W-1:0] arr_q;
	logic [PROC_W-1:0] proc_q;
	logic [TIME_W-1:0] st_q;
	logic              drop_q;
	logic              dropped_q;
	logic [TIME_W-1:0] start_q;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [TIME_W-1:0] rd_data;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     head_inc;
	logic [SW-1:0]     tail_sum;
	logic [AW-1:0]     tail;
	logic [LIM_W-1:0]  bsz_ext;
	logic [LIM_W-1:0]  lim;
	logic              full;
	logic              pop;
	logic              out_free;
	logic              wr_en;
	logic              cfg_wr;

	bpbs_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	bpbs_ring #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail),
		.wr_data (alu_rsp.sum),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		alu_req.op = ALU_LE;
		alu_req.a  = rd_data;
		alu_req.b  = arr_q;
		case (state_q)
			ST_MAX: begin
				alu_req.a = last_q;
			end
			ST_ADD: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = st_q;
				alu_req.b  = {{(TIME_W-PROC_W){1'b0}}, proc_q};
			end
			default: begin
				alu_req.op = ALU_LE;
			end
		endcase
	end

	assign pop      = (state_q == ST_CMP) && (occ_q != '0) && alu_rsp.le;
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign rd_addr  = pop ? head_inc : head_q;
	assign tail_sum = SW'(head_q) + SW'(occ_q);
	assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
	assign bsz_ext  = LIM_W'(bsz_q);
	assign lim      = (bsz_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : bsz_ext;
	assign full     = (LIM_W'(occ_q) >= lim);
	assign out_free = !res_valid_q || !res_stall;
	assign wr_en    = (state_q == ST_ADD) && out_free && !drop_q;
	assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_BUFFER_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			occ_q       <= '0;
			last_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && state_q != ST_ADD) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pkt_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (pop) begin
						head_q <= head_inc;
						occ_q  <= occ_q - 1'b1;
					end else if (full) begin
						state_q <= ST_ADD;
					end else begin
						state_q <= ST_MAX;
					end
				end
				ST_MAX: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (!drop_q) begin
							last_q <= alu_rsp.sum;
							occ_q  <= occ_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsz_q <= BUF_SIZE_RST;
		end else if (cfg_wr) begin
			bsz_q <= pwdata[CFG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pkt_valid) begin
			arr_q  <= arrival_tick;
			proc_q <= service_ticks;
		end
		if (state_q == ST_CMP && !pop) begin
			drop_q <= full;
		end
		if (state_q == ST_MAX) begin
			st_q <= alu_rsp.le ? arr_q : last_q;
		end
		if (state_q == ST_ADD && out_free) begin
			dropped_q <= drop_q;
			start_q   <= drop_q ? last_q : st_q;
		end
	end

	assign pkt_stall  = (state_q != ST_IDLE);
	assign res_valid  = res_valid_q;
	assign dropped    = dropped_q;
	assign start_tick = start_q;
	assign pready     = 1'b1;
	assign prdata     = (paddr == ADDR_BUFFER_SIZE) ? APB_DW'(bsz_q) : '0;

endmodule

>>> sv/bpbs_checker.sv
// Port-level assertions for the packet buffer simulator, bound to the top level.
module bpbs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        pready,
	input logic [bpbs_pkg::APB_DW-1:0] prdata,
	input logic                        pkt_valid,
	input logic                        pkt_stall,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic                        dropped,
	input logic [bpbs_pkg::TIME_W-1:0] start_tick
);
	import bpbs_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(dropped) && $stable(start_tick))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_stall |=> pkt_stall)
		else $error("request accepted but block not busy");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pkt_stall))
		else $error("result appeared with no request in flight");

	a_cfg_port: assert property (@(posedge clk) disable iff (!arst_n)
		pready && (prdata[APB_DW-1:CFG_W] == '0))
		else $error("config port readback out of range");

endmodule

bind bounded_packet_buffer_sim_unit bpbs_checker u_bpbs_checker (.*);

>>> test/bounded_packet_buffer_sim_unit_tb.sv
// Self-checking testbench for the tail-drop packet buffer simulator.
module bounded_packet_buffer_sim_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bpbs_pkg::*;

	localparam int DEPTH           = 64;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int RANDOM_PHASES   = 12;
	localparam int PHASE_REQUESTS  = 95;

	typedef struct {
		logic              dropped;
		logic [TIME_W-1:0] start;
	} pkt_outcome_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              pkt_valid;
	logic              pkt_stall;
	logic [TIME_W-1:0] arrival_tick;
	logic [PROC_W-1:0] service_ticks;
	logic              res_valid;
	logic              res_stall;
	logic              dropped;
	logic [TIME_W-1:0] start_tick;

	// shadow of the buffer state
	logic [TIME_W-1:0] done_ticks [DEPTH];
	logic [5:0]        ring_head;
	logic [CFG_W-1:0]  ring_count;
	logic [TIME_W-1:0] tail_finish;
	logic [CFG_W-1:0]  cap_reg;

	pkt_outcome_t pending_outcomes[$];
	logic [TIME_W-1:0] now_tick;
	bit  gaps_on      = 1'b1;
	bit  hold_off_req = 1'b0;
	int  mismatches   = 0;
	int  requests     = 0;
	int  results      = 0;
	int  drops_seen   = 0;
	int  size_writes  = 0;
	int  cycles       = 0;

	bounded_packet_buffer_sim_unit #(.DEPTH(DEPTH)) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.pkt_valid     (pkt_valid),
		.pkt_stall     (pkt_stall),
		.arrival_tick  (arrival_tick),
		.service_ticks (service_ticks),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.dropped       (dropped),
		.start_tick    (start_tick)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_outcomes.size());
			$display("bounded_packet_buffer_sim_unit_tb: FAIL");
			$finish;
		end
	end

	function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %h, got %h", what, want, got);
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic void clear_shadow();
		ring_head   = '0;
		ring_count  = '0;
		tail_finish = '0;
		cap_reg     = BUF_SIZE_RST;
	endfunction

	function automatic pkt_outcome_t admit_packet(logic [TIME_W-1:0] arr,
			logic [PROC_W-1:0] proc);
		pkt_outcome_t o;
		logic [CFG_W-1:0] cap;
		logic [5:0] slot;
		cap = (cap_reg > CFG_W'(DEPTH)) ? CFG_W'(DEPTH) : cap_reg;
		while (ring_count != 0 && done_ticks[ring_head] <= arr) begin
			ring_head  = ring_head + 6'd1;
			ring_count = ring_count - 1'b1;
		end
		if (ring_count < cap) begin
			o.dropped   = 1'b0;
			o.start     = (arr >= tail_finish) ? arr : tail_finish;
			tail_finish = o.start + TIME_W'(proc);
			slot        = ring_head + ring_count[5:0];
			done_ticks[slot] = tail_finish;
			ring_count  = ring_count + 1'b1;
		end else begin
			o.dropped = 1'b1;
			o.start   = tail_finish;
		end
		return o;
	endfunction

	// result monitor
	always @(posedge clk) begin
		pkt_outcome_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			results++;
			if (dropped === 1'b1)
				drops_seen++;
			if (pending_outcomes.size() == 0) begin
				flag_mismatch("unexpected result, start_tick", '0, start_tick);
			end else begin
				want = pending_outcomes.pop_front();
				if (dropped !== want.dropped)
					flag_mismatch("dropped", 32'(want.dropped), 32'(dropped));
				if (start_tick !== want.start)
					flag_mismatch("start_tick", want.start, start_tick);
			end
		end
	end

	// result-side stall generator
	initial begin : result_side
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				res_stall <= 1'b0;
				hold_off_req = 1'b0;
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				res_stall <= 1'b1;
				repeat (gap_len()) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_pkt(input logic [TIME_W-1:0] arr, input logic [PROC_W-1:0] proc);
		int gap;
		gap = (gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			pkt_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pkt_valid     <= 1'b1;
		arrival_tick  <= arr;
		service_ticks <= proc;
		do @(posedge clk); while (pkt_stall !== 1'b0);
		pending_outcomes.insert(pending_outcomes.size(), admit_packet(arr, proc));
		requests++;
		@(negedge clk);
	endtask

	task automatic quiesce();
		pkt_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_buffer_size(input logic [CFG_W-1:0] val);
		quiesce();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BUFFER_SIZE;
		pwdata  <= APB_DW'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		cap_reg = val;
		size_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[CFG_W-1:0] !== val)
			flag_mismatch("buffer_size readback", 32'(val), 32'(prdata[CFG_W-1:0]));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_field_extremes();
		send_pkt(32'h0000_0000, 16'h0000);
		send_pkt(32'h0000_0000, 16'hFFFF);
		send_pkt(32'hFFFF_FFFF, 16'hFFFF);
		send_pkt(32'h0000_0005, 16'h0003);
		send_pkt(32'hFFFF_FFFF, 16'h0000);
	endtask

	task automatic test_zero_size();
		set_buffer_size(7'd0);
		send_pkt(32'h0000_0100, 16'h1234);
		send_pkt(32'h8000_0000, 16'h0001);
	endtask

	task automatic test_single_slot();
		set_buffer_size(7'd1);
		send_pkt(32'hFFFF_FFFF, 16'h0010);
		send_pkt(32'h0000_1000, 16'h0100);
		send_pkt(32'h0000_1000, 16'h0001);
	endtask

	task automatic test_shrink_below_fill();
		set_buffer_size(7'd127);
		for (int i = 0; i < 6; i++)
			send_pkt(32'h0002_0000, 16'h0040);
		set_buffer_size(7'd2);
		for (int i = 0; i < 3; i++)
			send_pkt(32'h0002_0040, 16'h0008);
		send_pkt(32'h0002_0180, 16'h0004);
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] sizes [RANDOM_PHASES] =
			'{7'd64, 7'd127, 7'd2, 7'd0, 7'd1, 7'd64, 7'd33, 7'd127, 7'd5, 7'd64, 7'd3, 7'd127};
		int pmax;
		int inc_max;
		bit heavy;
		logic [TIME_W-1:0] arr;
		logic [PROC_W-1:0] proc;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_buffer_size(sizes[ph]);
			gaps_on = (ph % 3 != 2);
			case ($urandom_range(0, 2))
				0: pmax = 3;
				1: pmax = 255;
				default: pmax = 65535;
			endcase
			heavy   = ($urandom_range(0, 3) != 0);
			inc_max = heavy ? pmax / 4 : pmax * 2;
			if (ph % 4 == 1)
				now_tick = 32'hFFFF_FFFF - $urandom_range(0, 200000);
			for (int i = 0; i < PHASE_REQUESTS; i++) begin
				if ($urandom_range(0, 19) == 0)
					arr = $urandom();
				else
					arr = now_tick + $urandom_range(0, inc_max);
				now_tick = arr;
				proc = PROC_W'($urandom_range(0, pmax));
				send_pkt(arr, proc);
			end
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		set_buffer_size(7'd64);
		gaps_on = 1'b0;
		hold_off_req = 1'b1;
		for (int i = 0; i < 30; i++) begin
			now_tick = now_tick + $urandom_range(0, 50);
			send_pkt(now_tick, 16'($urandom_range(0, 400)));
		end
		quiesce();
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		pkt_valid     = 1'b0;
		arrival_tick  = '0;
		service_ticks = '0;
		now_tick      = '0;
		clear_shadow();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		test_field_extremes();
		test_zero_size();
		test_single_slot();
		test_shrink_below_fill();
		test_random_traffic();
		test_backpressure();

		quiesce();
		repeat (100) @(negedge clk);
		$display("run covered %0d packets, %0d results (%0d dropped), %0d buffer_size writes,",
			requests, results, drops_seen, size_writes);
		$display("time wrap, shrinking below fill and a %0d-cycle result hold-off; %0d mismatches",
			HOLD_OFF_CYCLES, mismatches);
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("bounded_packet_buffer_sim_unit_tb: PASS");
		else
			$display("bounded_packet_buffer_sim_unit_tb: FAIL");
		$finish;
	end

endmodule
